// File: src/alpha_weighted_image_rescaler_assert.svh
// Assertion macros used by the rescaler checker.
`ifndef ALPHA_WEIGHTED_IMAGE_RESCALER_ASSERT_SVH
`define ALPHA_WEIGHTED_IMAGE_RESCALER_ASSERT_SVH

// Same-cycle implication.
`define AWIR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rescaler assertion failed");

// Next-cycle implication.
`define AWIR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rescaler assertion failed");

`endif

// File: src/awir_pkg.sv
// ----------------------------------------------------------------------------
// awir_pkg
// Shared widths, codes and defaults of the alpha-weighted image rescaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package awir_pkg;

	localparam int unsigned MAX_SRC_WIDTH_D  = 256;
	localparam int unsigned MAX_SRC_HEIGHT_D = 256;
	localparam int unsigned MAX_DST_SIDE_D   = 4096;

	localparam int unsigned POS_W     = 12;
	localparam int unsigned CFG_W     = 13;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned SRC_W     = 9;
	localparam int unsigned DST_W     = 13;
	localparam int unsigned DIV_W     = 50;
	localparam int unsigned SUM_W     = 48;
	localparam int unsigned SA_W      = 41;
	localparam int unsigned WGT_W     = 33;

	// word function codes
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PREMULT    = 3'd4;

endpackage

// File: src/alpha_weighted_image_rescaler.sv
// ----------------------------------------------------------------------------
// alpha_weighted_image_rescaler
// Frame store plus sequenced area-average / bilinear resampler with one
// shared restoring divider.
// ----------------------------------------------------------------------------
// A load word writes one RGBA entry. A query word is worked by a sequencer
// around one 50-bit restoring divider that retires one quotient bit a cycle.
// Box mode takes 4 divisions for the region bounds, one store read and one
// accumulate step per source pixel of the region, and 4 divisions for alpha
// and colour. Bilinear mode takes 2 divisions for the axis positions, a
// weight, an alpha product and an accumulate step for each of four taps, and
// 3 divisions for straight colour; with premultiplied colour each channel is
// a shift and a reciprocal step, with no division. Input stalls while a query
// is in work; a finished word waits in the output register without blocking
// load words.
`timescale 1ns / 1ps

module alpha_weighted_image_rescaler #(
	parameter int unsigned MAX_SRC_WIDTH  = awir_pkg::MAX_SRC_WIDTH_D,
	parameter int unsigned MAX_SRC_HEIGHT = awir_pkg::MAX_SRC_HEIGHT_D,
	parameter int unsigned MAX_DST_SIDE   = awir_pkg::MAX_DST_SIDE_D
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [awir_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [awir_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           func,
	input  logic [awir_pkg::POS_W-1:0]     pos_x,
	input  logic [awir_pkg::POS_W-1:0]     pos_y,
	input  logic [7:0]                     in_r,
	input  logic [7:0]                     in_g,
	input  logic [7:0]                     in_b,
	input  logic [7:0]                     in_a,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     out_b,
	output logic [7:0]                     out_g,
	output logic [7:0]                     out_r,
	output logic [7:0]                     out_a,
	output logic                           status
);
	import awir_pkg::*;

	localparam int unsigned DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [4:0] {
		S_IDLE, S_CHK, S_DIV,
		S_B1, S_B2, S_B3, S_B4, S_BRD, S_BACC, S_BCNT, S_BDIV, S_BCOL,
		S_L1, S_L2, S_LW, S_LA, S_LS, S_LF, S_LDIV, S_LCOL,
		S_OUT
	} state_t;

	function automatic logic [DST_W-1:0] clamp_side(input logic [DST_W-1:0] v,
			input logic [16:0] hi);
		logic [DST_W-1:0] r;
		r = v;
		if (v == '0) r = DST_W'(1);
		else if ({4'b0, v} > hi) r = hi[DST_W-1:0];
		return r;
	endfunction

	// configuration
	logic [SRC_W-1:0] src_w_q, src_h_q;
	logic [DST_W-1:0] dst_w_q, dst_h_q;
	logic             premult_q;

	// sequencer and datapath registers
	state_t            state_q, ret_q;
	logic [POS_W-1:0]  px_q, py_q;
	logic [DIV_W-1:0]  num_q, den_q, rem_q;
	logic [5:0]        dcnt_q;
	logic [SRC_W-1:0]  x0_q, x1_q, y0_q, y1_q, sx_q, sy_q;
	logic [15:0]       wx_q, wy_q;
	logic [1:0]        k_q, c_q;
	logic [WGT_W-1:0]  w_q;
	logic [SA_W-1:0]   aw_q, sa_q;
	logic [SUM_W-1:0]  sum_q [3];
	logic [17:0]       cnt_q;
	logic [7:0]        res_q [4];
	logic              out_valid_q, status_q;
	logic [7:0]        ob_q, og_q, or_q, oa_q;

	// frame store
	logic [31:0]       mem [DEPTH];
	logic [31:0]       rdata_q;
	logic              mem_we, mem_re;
	logic [AW-1:0]     waddr, raddr;
	logic [SRC_W-1:0]  rx, ry;

	// clamped geometry
	logic [DST_W-1:0] sw, sh, dw, dh;
	assign sw = clamp_side({4'b0, src_w_q}, 17'(MAX_SRC_WIDTH));
	assign sh = clamp_side({4'b0, src_h_q}, 17'(MAX_SRC_HEIGHT));
	assign dw = clamp_side(dst_w_q, 17'(MAX_DST_SIDE));
	assign dh = clamp_side(dst_h_q, 17'(MAX_DST_SIDE));

	// divider step
	logic [DIV_W:0]   rem_sh, rem_sub;
	logic             ge;
	assign rem_sh  = {rem_q, num_q[DIV_W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign ge      = (rem_sh >= {1'b0, den_q});

	// bilinear axis mapping: x axis in S_CHK, y axis in S_L1
	logic [POS_W-1:0] ax_d;
	logic [DST_W-1:0] ax_s, ax_n;
	logic [25:0]      lhs;
	logic [DIV_W-1:0] map_num, map_den;
	always_comb begin
		ax_d = (state_q == S_CHK) ? px_q : py_q;
		ax_s = (state_q == S_CHK) ? sw : sh;
		ax_n = (state_q == S_CHK) ? dw : dh;
		lhs  = ({13'b0, ax_d, 1'b1}) * 26'(ax_s);
		map_num = '0;
		if (lhs > 26'(ax_n))
			map_num = DIV_W'({lhs - 26'(ax_n), 16'b0}) + DIV_W'(ax_n);
		map_den = DIV_W'({ax_n, 1'b0});
	end

	// tap selection from the quotient of the axis division: x taps in S_L1,
	// y taps in S_L2
	logic [DST_W-1:0] tap_s;
	logic [SRC_W-1:0] t0, t0c, t1c, smax;
	logic [15:0]      fr;
	always_comb begin
		tap_s = (state_q == S_L1) ? sw : sh;
		t0    = num_q[24:16];
		fr    = num_q[15:0];
		smax  = SRC_W'(tap_s - 13'd1);
		t0c   = (t0 > smax) ? smax : t0;
		t1c   = ({1'b0, t0c} + 10'd1 < 10'(tap_s)) ? t0c + SRC_W'(1) : t0c;
	end

	// bilinear weight of tap k
	logic [16:0] wxf, wyf;
	logic [33:0] wprod;
	always_comb begin
		wxf   = k_q[0] ? {1'b0, wx_q} : 17'd65536 - {1'b0, wx_q};
		wyf   = k_q[1] ? {1'b0, wy_q} : 17'd65536 - {1'b0, wy_q};
		wprod = {17'b0, wxf} * {17'b0, wyf};
	end

	// premultiplied bilinear colour: add 255 halves of 2^32 to the sum, scale it to units
	// of 2^32, then divide by 255 with a reciprocal step (exact below 65535)
	logic [DIV_W-1:0] pm_num;
	logic [16:0]      pm_v, pm_div;
	always_comb begin
		pm_num = {1'b0, sum_q[c_q], 1'b0} + (DIV_W'(255) << 32);
		pm_v   = pm_num[DIV_W-1:33];
		pm_div = (pm_v + 17'd1 + (pm_v >> 8)) >> 8;
	end

	// store port control
	always_comb begin
		mem_we = (state_q == S_IDLE) && in_valid && (func == FUNC_LOAD)
			&& (32'(pos_x) < MAX_SRC_WIDTH) && (32'(pos_y) < MAX_SRC_HEIGHT);
		waddr  = AW'(32'(pos_y) * MAX_SRC_WIDTH + 32'(pos_x));
		mem_re = (state_q == S_BRD) || (state_q == S_LW);
		rx     = (state_q == S_BRD) ? sx_q : (k_q[0] ? x1_q : x0_q);
		ry     = (state_q == S_BRD) ? sy_q : (k_q[1] ? y1_q : y0_q);
		raddr  = AW'(32'(ry) * MAX_SRC_WIDTH + 32'(rx));
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= {in_a, in_b, in_g, in_r};
		if (mem_re) rdata_q <= mem[raddr];
	end

	// box bounds
	logic [SRC_W-1:0] quo9, lo_q;
	assign quo9 = num_q[SRC_W-1:0];
	assign lo_q = (state_q == S_B2) ? x0_q : y0_q;

	// accumulate terms
	logic [7:0] pa;
	assign pa = rdata_q[31:24];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			src_w_q     <= SRC_W'(1);
			src_h_q     <= SRC_W'(1);
			dst_w_q     <= DST_W'(1);
			dst_h_q     <= DST_W'(1);
			premult_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// hold configuration
			if (cfg_we) begin
				case (cfg_index)
					REG_SRC_WIDTH:  src_w_q   <= cfg_wdata[SRC_W-1:0];
					REG_SRC_HEIGHT: src_h_q   <= cfg_wdata[SRC_W-1:0];
					REG_DST_WIDTH:  dst_w_q   <= cfg_wdata[DST_W-1:0];
					REG_DST_HEIGHT: dst_h_q   <= cfg_wdata[DST_W-1:0];
					REG_PREMULT:    premult_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			// drop the output word once taken, unless a new one replaces it
			if (out_valid_q && !out_stall && state_q != S_OUT) out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid && func == FUNC_QUERY) begin
						px_q    <= pos_x;
						py_q    <= pos_y;
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					res_q  <= '{default: '0};
					rem_q  <= '0;
					dcnt_q <= '0;
					if (13'(px_q) >= dw || 13'(py_q) >= dh) begin
						status_q <= 1'b1;
						state_q  <= S_OUT;
					end else if (dw < sw || dh < sh) begin
						num_q   <= DIV_W'(25'(px_q) * 25'(sw));
						den_q   <= DIV_W'(dw);
						ret_q   <= S_B1;
						state_q <= S_DIV;
					end else begin
						num_q   <= map_num;
						den_q   <= map_den;
						ret_q   <= S_L1;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					num_q  <= {num_q[DIV_W-2:0], ge};
					rem_q  <= ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
					dcnt_q <= dcnt_q + 6'd1;
					if (dcnt_q == 6'(DIV_W - 1)) state_q <= ret_q;
				end

				// area average
				S_B1: begin
					x0_q    <= quo9;
					num_q   <= DIV_W'(26'(px_q + 13'd1) * 26'(sw));
					den_q   <= DIV_W'(dw);
					rem_q   <= '0;
					dcnt_q  <= '0;
					ret_q   <= S_B2;
					state_q <= S_DIV;
				end
				S_B2, S_B4: begin
					if (state_q == S_B2)
						x1_q <= (quo9 <= lo_q) ? lo_q + SRC_W'(1) : quo9;
					else
						y1_q <= (quo9 <= lo_q) ? lo_q + SRC_W'(1) : quo9;
					rem_q  <= '0;
					dcnt_q <= '0;
					if (state_q == S_B2) begin
						num_q   <= DIV_W'(25'(py_q) * 25'(sh));
						den_q   <= DIV_W'(dh);
						ret_q   <= S_B3;
						state_q <= S_DIV;
					end else begin
						sx_q    <= x0_q;
						sy_q    <= y0_q;
						sa_q    <= '0;
						sum_q   <= '{default: '0};
						state_q <= S_BRD;
					end
				end
				S_B3: begin
					y0_q    <= quo9;
					num_q   <= DIV_W'(26'(py_q + 13'd1) * 26'(sh));
					den_q   <= DIV_W'(dh);
					rem_q   <= '0;
					dcnt_q  <= '0;
					ret_q   <= S_B4;
					state_q <= S_DIV;
				end
				S_BRD: state_q <= S_BACC;
				S_BACC: begin
					sa_q     <= sa_q + SA_W'(pa);
					sum_q[0] <= sum_q[0] + SUM_W'(rdata_q[7:0]) * SUM_W'(pa);
					sum_q[1] <= sum_q[1] + SUM_W'(rdata_q[15:8]) * SUM_W'(pa);
					sum_q[2] <= sum_q[2] + SUM_W'(rdata_q[23:16]) * SUM_W'(pa);
					state_q  <= S_BRD;
					if ({1'b0, sx_q} + 10'd1 < {1'b0, x1_q}) begin
						sx_q <= sx_q + SRC_W'(1);
					end else begin
						sx_q <= x0_q;
						if ({1'b0, sy_q} + 10'd1 < {1'b0, y1_q}) sy_q <= sy_q + SRC_W'(1);
						else state_q <= S_BCNT;
					end
				end
				S_BCNT: begin
					cnt_q <= 18'(x1_q - x0_q) * 18'(y1_q - y0_q);
					c_q   <= 2'd3;
					if (sa_q == '0) begin
						status_q <= 1'b0;
						state_q  <= S_OUT;
					end else begin
						state_q <= S_BDIV;
					end
				end
				S_BDIV: begin
					rem_q  <= '0;
					dcnt_q <= '0;
					if (c_q == 2'd3) begin
						num_q <= DIV_W'(sa_q);
						den_q <= DIV_W'(cnt_q);
					end else begin
						num_q <= DIV_W'(sum_q[c_q]);
						den_q <= premult_q ? DIV_W'(26'(cnt_q) * 26'd255) : DIV_W'(sa_q);
					end
					ret_q   <= S_BCOL;
					state_q <= S_DIV;
				end
				S_BCOL: begin
					res_q[c_q] <= num_q[7:0];
					if (c_q == 2'd2) begin
						status_q <= 1'b0;
						state_q  <= S_OUT;
					end else begin
						c_q     <= (c_q == 2'd3) ? 2'd0 : c_q + 2'd1;
						state_q <= S_BDIV;
					end
				end

				// bilinear
				S_L1: begin
					x0_q    <= t0c;
					x1_q    <= t1c;
					wx_q    <= fr;
					num_q   <= map_num;
					den_q   <= map_den;
					rem_q   <= '0;
					dcnt_q  <= '0;
					ret_q   <= S_L2;
					state_q <= S_DIV;
				end
				S_L2: begin
					y0_q    <= t0c;
					y1_q    <= t1c;
					wy_q    <= fr;
					k_q     <= '0;
					sa_q    <= '0;
					sum_q   <= '{default: '0};
					state_q <= S_LW;
				end
				S_LW: begin
					w_q     <= wprod[WGT_W-1:0];
					state_q <= S_LA;
				end
				S_LA: begin
					aw_q    <= SA_W'(w_q) * SA_W'(pa);
					state_q <= S_LS;
				end
				S_LS: begin
					sa_q     <= sa_q + aw_q;
					sum_q[0] <= sum_q[0] + SUM_W'(SUM_W'(aw_q) * SUM_W'(rdata_q[7:0]));
					sum_q[1] <= sum_q[1] + SUM_W'(SUM_W'(aw_q) * SUM_W'(rdata_q[15:8]));
					sum_q[2] <= sum_q[2] + SUM_W'(SUM_W'(aw_q) * SUM_W'(rdata_q[23:16]));
					k_q      <= k_q + 2'd1;
					state_q  <= (k_q == 2'd3) ? S_LF : S_LW;
				end
				S_LF: begin
					c_q <= 2'd0;
					if (sa_q == '0) begin
						status_q <= 1'b0;
						state_q  <= S_OUT;
					end else begin
						res_q[3] <= 8'((sa_q + (SA_W'(1) << 31)) >> 32);
						state_q  <= S_LDIV;
					end
				end
				S_LDIV: begin
					if (premult_q) begin
						// reciprocal step per channel, no divider
						res_q[c_q] <= pm_div[7:0];
						if (c_q == 2'd2) begin
							status_q <= 1'b0;
							state_q  <= S_OUT;
						end else begin
							c_q <= c_q + 2'd1;
						end
					end else begin
						rem_q   <= '0;
						dcnt_q  <= '0;
						num_q   <= {1'b0, sum_q[c_q], 1'b0} + DIV_W'(sa_q);
						den_q   <= DIV_W'({sa_q, 1'b0});
						ret_q   <= S_LCOL;
						state_q <= S_DIV;
					end
				end
				S_LCOL: begin
					res_q[c_q] <= num_q[7:0];
					if (c_q == 2'd2) begin
						status_q <= 1'b0;
						state_q  <= S_OUT;
					end else begin
						c_q     <= c_q + 2'd1;
						state_q <= S_LDIV;
					end
				end

				// advance the result into the output register
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						or_q        <= res_q[0];
						og_q        <= res_q[1];
						ob_q        <= res_q[2];
						oa_q        <= res_q[3];
						status      <= status_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_b     = ob_q;
	assign out_g     = og_q;
	assign out_r     = or_q;
	assign out_a     = oa_q;

endmodule

// File: src/awir_checker.sv
// ----------------------------------------------------------------------------
// awir_checker
// Port-level assertions of the rescaler, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "alpha_weighted_image_rescaler_assert.svh"

module awir_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           func,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [7:0]                     out_b,
	input logic [7:0]                     out_g,
	input logic [7:0]                     out_r,
	input logic [7:0]                     out_a,
	input logic                           status
);
	import awir_pkg::*;

	// stalled output word holds its valid, blue, alpha and status
	`AWIR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_b) && $stable(out_a) && $stable(status))

	// a query occupies the sequencer on the next cycle
	`AWIR_ASSERT_NEXT(a_query_busy, clk, arst_n, in_valid && !in_stall && func == FUNC_QUERY, in_stall)

	// an out-of-range word carries a zero pixel
	`AWIR_ASSERT_IMPL(a_status_zero, clk, arst_n, out_valid && status, out_b == 8'd0 && out_g == 8'd0 && out_r == 8'd0 && out_a == 8'd0)

	// a load word creates no output word
	`AWIR_ASSERT_NEXT(a_load_silent, clk, arst_n, in_valid && !in_stall && func == FUNC_LOAD && !out_valid, !out_valid)

endmodule

bind alpha_weighted_image_rescaler awir_checker u_awir_checker (.*);

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the alpha-weighted image rescaler: loads source
// frames, queries destination pixels under many size settings and idle
// patterns, and checks every returned word against an in-bench predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import awir_pkg::*;

	typedef struct packed {
		logic             func;
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [7:0]       r;
		logic [7:0]       g;
		logic [7:0]       b;
		logic [7:0]       a;
	} word_t;

	typedef struct packed {
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
		logic [7:0] a;
		logic       status;
	} pixel_t;

	// Predicts destination pixels and holds the ones still owed by the block.
	class rescale_scoreboard;
		bit [31:0]   frame [0:65535];
		int unsigned src_w = 1, src_h = 1, dst_w = 1, dst_h = 1;
		bit          premult = 0;
		pixel_t      owed[$];
		int          errors = 0, loads = 0, queries = 0, flagged = 0, checked = 0;

		function void set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
			case (idx)
				REG_SRC_WIDTH:  src_w = v & 'h1ff;
				REG_SRC_HEIGHT: src_h = v & 'h1ff;
				REG_DST_WIDTH:  dst_w = v & 'h1fff;
				REG_DST_HEIGHT: dst_h = v & 'h1fff;
				REG_PREMULT:    premult = v[0];
				default: ;
			endcase
		endfunction

		function longint unsigned clamp(int unsigned v, int unsigned hi);
			return (v < 1) ? 1 : (v > hi) ? hi : v;
		endfunction

		function longint unsigned chan(bit [31:0] p, int c);
			return (p >> (8 * c)) & 8'hff;
		endfunction

		// Map one destination index to two clamped taps and a Q16 fraction.
		function void axis(longint unsigned d, longint unsigned s, longint unsigned n,
				output longint unsigned t0, output longint unsigned t1,
				output longint unsigned fr);
			longint unsigned lhs, q;
			lhs = (2 * d + 1) * s;
			q = 0;
			if (lhs > n) q = ((lhs - n) * 65536 + n) / (2 * n);
			t0 = q >> 16;
			fr = q & 'hffff;
			if (t0 > s - 1) t0 = s - 1;
			t1 = (t0 + 1 < s) ? t0 + 1 : t0;
		endfunction

		function pixel_t resample(longint unsigned px, longint unsigned py);
			longint unsigned sw, sh, dw, dh, sa, cnt, alpha;
			longint unsigned x0, x1, y0, y1, wx, wy, aw;
			longint unsigned sum [3];
			longint unsigned rgb [3];
			longint unsigned wgt [4];
			bit [31:0] p [4];
			bit [31:0] q;
			pixel_t res;
			sw = clamp(src_w, MAX_SRC_WIDTH_D);
			sh = clamp(src_h, MAX_SRC_HEIGHT_D);
			dw = clamp(dst_w, MAX_DST_SIDE_D);
			dh = clamp(dst_h, MAX_DST_SIDE_D);
			res = '0;
			sa = 0;
			for (int c = 0; c < 3; c++) sum[c] = 0;
			if (px >= dw || py >= dh) begin
				res.status = 1'b1;
				return res;
			end
			if (dw < sw || dh < sh) begin
				// area average over the covered source rectangle
				x0 = px * sw / dw; x1 = (px + 1) * sw / dw;
				y0 = py * sh / dh; y1 = (py + 1) * sh / dh;
				if (x1 <= x0) x1 = x0 + 1;
				if (y1 <= y0) y1 = y0 + 1;
				for (longint unsigned sy = y0; sy < y1; sy++)
					for (longint unsigned sx = x0; sx < x1; sx++) begin
						q = frame[sy * MAX_SRC_WIDTH_D + sx];
						for (int c = 0; c < 3; c++) sum[c] += chan(q, c) * chan(q, 3);
						sa += chan(q, 3);
					end
				if (sa == 0) return res;
				cnt = (x1 - x0) * (y1 - y0);
				alpha = sa / cnt;
				for (int c = 0; c < 3; c++)
					rgb[c] = premult ? sum[c] / cnt / 255 : sum[c] / sa;
			end else begin
				// bilinear over four taps with Q32 weights
				axis(px, sw, dw, x0, x1, wx);
				axis(py, sh, dh, y0, y1, wy);
				p[0] = frame[y0 * MAX_SRC_WIDTH_D + x0];
				p[1] = frame[y0 * MAX_SRC_WIDTH_D + x1];
				p[2] = frame[y1 * MAX_SRC_WIDTH_D + x0];
				p[3] = frame[y1 * MAX_SRC_WIDTH_D + x1];
				wgt[0] = (65536 - wx) * (65536 - wy);
				wgt[1] = wx * (65536 - wy);
				wgt[2] = (65536 - wx) * wy;
				wgt[3] = wx * wy;
				for (int k = 0; k < 4; k++) begin
					aw = chan(p[k], 3) * wgt[k];
					sa += aw;
					for (int c = 0; c < 3; c++) sum[c] += chan(p[k], c) * aw;
				end
				if (sa == 0) return res;
				alpha = (sa + 64'h8000_0000) >> 32;
				for (int c = 0; c < 3; c++)
					rgb[c] = premult ?
						(2 * sum[c] + 255 * 64'h1_0000_0000) / (2 * 255 * 64'h1_0000_0000) :
						(2 * sum[c] + sa) / (2 * sa);
			end
			res.b = rgb[2][7:0];
			res.g = rgb[1][7:0];
			res.r = rgb[0][7:0];
			res.a = alpha[7:0];
			return res;
		endfunction

		function void note_input(word_t w);
			pixel_t exp_px;
			if (w.func == FUNC_LOAD) begin
				loads++;
				if (w.x < MAX_SRC_WIDTH_D && w.y < MAX_SRC_HEIGHT_D)
					frame[w.y * MAX_SRC_WIDTH_D + w.x] = {w.a, w.b, w.g, w.r};
			end else begin
				queries++;
				exp_px = resample(w.x, w.y);
				if (exp_px.status) flagged++;
				owed.push_back(exp_px);
			end
		endfunction

		function void check_result(pixel_t got);
			pixel_t want;
			if (owed.size() == 0) begin
				errors++;
				$display("%0t: unexpected word %h", $time, got);
				return;
			end
			want = owed.pop_front();
			checked++;
			if (got.b !== want.b)
				begin errors++; $display("%0t: out_b exp %h got %h", $time, want.b, got.b); end
			if (got.g !== want.g)
				begin errors++; $display("%0t: out_g exp %h got %h", $time, want.g, got.g); end
			if (got.r !== want.r)
				begin errors++; $display("%0t: out_r exp %h got %h", $time, want.r, got.r); end
			if (got.a !== want.a)
				begin errors++; $display("%0t: out_a exp %h got %h", $time, want.a, got.a); end
			if (got.status !== want.status) begin
				errors++;
				$display("%0t: status exp %b got %b", $time, want.status, got.status);
			end
		endfunction
	endclass

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_SRC_WIDTH;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	logic                 in_valid = 0;
	logic                 in_stall;
	logic                 func = FUNC_LOAD;
	logic [POS_W-1:0]     pos_x = '0, pos_y = '0;
	logic [7:0]           in_r = 0, in_g = 0, in_b = 0, in_a = 0;
	logic                 out_valid;
	logic                 out_stall = 0;
	logic [7:0]           out_b, out_g, out_r, out_a;
	logic                 status;

	rescale_scoreboard sb = new();
	int idle_mode = 0;  // 0 none, 1 sender, 2 receiver, 3 both

	alpha_weighted_image_rescaler i_dut (.*);

	always #6 clk = ~clk;

	// Note accepted words and check returned pixels.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_input({func, pos_x, pos_y, in_r, in_g, in_b, in_a});
		if (arst_n && out_valid && !out_stall)
			sb.check_result({out_b, out_g, out_r, out_a, status});
	end

	// Stall the result side according to the idle mode.
	always @(posedge clk) begin
		case (idle_mode)
			2: out_stall <= $urandom_range(0, 99) < 61;
			3: out_stall <= $urandom_range(0, 99) < 17;
			default: out_stall <= 1'b0;
		endcase
	end

	task automatic send(word_t w);
		int gap;
		gap = 0;
		if (idle_mode == 1 && $urandom_range(0, 99) < 61) gap = $urandom_range(1, 4);
		if (idle_mode == 3 && $urandom_range(0, 99) < 17) gap = $urandom_range(1, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		func <= w.func; pos_x <= w.x; pos_y <= w.y;
		in_r <= w.r; in_g <= w.g; in_b <= w.b; in_a <= w.a;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		if (in_valid) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		while (sb.owed.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Write one register, then leave the write port idle.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= CFG_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, v);
		@(posedge clk);
	endtask

	function automatic logic [7:0] rand_alpha();
		case ($urandom_range(0, 3))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic word_t load_word(int unsigned x, int unsigned y);
		return {FUNC_LOAD, x[POS_W-1:0], y[POS_W-1:0], 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), rand_alpha()};
	endfunction

	function automatic word_t query_word(int unsigned x, int unsigned y);
		return {FUNC_QUERY, x[POS_W-1:0], y[POS_W-1:0], 32'($urandom())};
	endfunction

	task automatic run_phase(int unsigned sw, int unsigned sh, int unsigned dw,
			int unsigned dh, bit pm, int n_rand, bit pause_mid, bit fill);
		int unsigned usw, ush, udw, udh, x, y;
		write_reg(REG_SRC_WIDTH, sw);
		write_reg(REG_SRC_HEIGHT, sh);
		write_reg(REG_DST_WIDTH, dw);
		write_reg(REG_DST_HEIGHT, dh);
		write_reg(REG_PREMULT, pm);
		usw = 32'(sb.clamp(sb.src_w, MAX_SRC_WIDTH_D));
		ush = 32'(sb.clamp(sb.src_h, MAX_SRC_HEIGHT_D));
		udw = 32'(sb.clamp(sb.dst_w, MAX_DST_SIDE_D));
		udh = 32'(sb.clamp(sb.dst_h, MAX_DST_SIDE_D));
		// fill the whole source area before any query reads it
		if (fill)
			for (int j = 0; j < ush; j++)
				for (int i = 0; i < usw; i++) send(load_word(i, j));
		for (int n = 0; n < n_rand; n++) begin
			if (pause_mid && n == n_rand / 2) drain();
			case ($urandom_range(0, 9))
				0: send(load_word($urandom_range(0, 4095), $urandom_range(0, 4095)));
				1, 2: send(load_word($urandom_range(0, usw - 1), $urandom_range(0, ush - 1)));
				3: send(query_word($urandom_range(0, 4095), $urandom_range(0, 4095)));
				default: begin
					x = $urandom_range(0, udw - 1);
					y = $urandom_range(0, udh - 1);
					send(query_word(x, y));
				end
			endcase
		end
		drain();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset sizes 1x1 to 1x1.
		send({FUNC_LOAD, 12'd0, 12'd0, 8'hff, 8'hff, 8'hff, 8'h00});
		send(query_word(0, 0));                        // zero total alpha
		send({FUNC_LOAD, 12'd0, 12'd0, 8'hff, 8'hff, 8'hff, 8'hff});
		send(query_word(0, 0));
		send(query_word(4095, 4095));                  // outside destination
		send(query_word(1, 0));
		send(query_word(0, 1));
		send({FUNC_LOAD, 12'hfff, 12'hfff, 8'h00, 8'h00, 8'h00, 8'h00}); // outside store
		send({FUNC_LOAD, 12'd255, 12'd255, 8'h5a, 8'ha5, 8'h3c, 8'hc3});
		send({FUNC_LOAD, 12'd0, 12'd0, 8'h00, 8'h00, 8'h00, 8'hff});
		send(query_word(0, 0));
		send({FUNC_LOAD, 12'd0, 12'd0, 8'h12, 8'h34, 8'h56, 8'h80});
		send(query_word(0, 0));
		drain();

		// Size settings: upscale, downscale, clamped extremes, then random ones.
		idle_mode = 1; run_phase(4, 3, 9, 7, 0, 50, 0, 1);
		idle_mode = 2; run_phase(8, 8, 3, 5, 1, 50, 1, 1);
		idle_mode = 3; run_phase(511, 1, 8191, 2, 1, 30, 0, 1);
		// same 256-wide source, squeezed into one pixel
		idle_mode = 1; run_phase(256, 1, 1, 1, 0, 15, 0, 0);
		idle_mode = 0; run_phase(0, 0, 0, 8191, 0, 30, 0, 1);
		for (int ph = 0; ph < 5; ph++) begin
			idle_mode = ph % 4;
			run_phase($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 24),
				$urandom_range(1, 24), $urandom_range(0, 1), 40, 0, 1);
		end
		idle_mode = 0;

		$display("covered %0d loads and %0d queries (%0d outside destination), %0d checked",
			sb.loads, sb.queries, sb.flagged, sb.checked);
		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Hard stop if the block hangs.
	initial begin
		#96ms;
		$display("timeout with %0d words owed", sb.owed.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
